// ===== rtl/tpgsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpgsa_pkg
// Shared types and constants for the two-part GLM score accumulator.
// ----------------------------------------------------------------------------
package tpgsa_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_W         = 64;
    localparam int DCNT_W        = $clog2(DIV_W);
    localparam int HORNER_TOP    = 6;

    // 2^f Taylor coefficients, Q30; last entry unused
    localparam logic [29:0] POW2_COEF [0:7] = '{
        30'd744261118, 30'd257941248, 30'd59597083, 30'd10327388,
        30'd1431680,   30'd165394,    30'd16378,    30'd0
    };

    localparam logic signed [32:0] LOG2E_Q30 = 33'sd1549082005;

    localparam logic PART_BIN = 1'b0;
    localparam logic PART_GAM = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_MUL_ZETA,
        OP_EXP_Y,
        OP_EXP_SPLIT,
        OP_HORNER_MUL,
        OP_HORNER_ADD,
        OP_EXP_FIN,
        OP_DIV_BIN_INIT,
        OP_DIV_Q_INIT,
        OP_DIV_STEP,
        OP_DIV_BIN_END,
        OP_DIV_Q_END,
        OP_GAM_E,
        OP_MUL_SE,
        OP_GAM_V,
        OP_MUL_W,
        OP_SAT_TMP,
        OP_MUL_X,
        OP_ACC,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       part;
        logic [2:0] idx;
    } cmd_t;

    typedef struct packed {
        logic use_bin;
        logic use_gam;
        logic final_item;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/tpgsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpgsa_ctrl
// Sequencer: steps the datapath through exp, divide and accumulate ops.
// ----------------------------------------------------------------------------
module tpgsa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tpgsa_pkg::status_t st,
    output tpgsa_pkg::cmd_t    cmd
);

    typedef enum logic [24:0] {
        S_IDLE    = 25'h0000001,
        S_BIN_CHK = 25'h0000002,
        S_GAM_CHK = 25'h0000004,
        S_FIN_CHK = 25'h0000008,
        S_ZMUL    = 25'h0000010,
        S_EXPY    = 25'h0000020,
        S_SPLIT   = 25'h0000040,
        S_HMUL    = 25'h0000080,
        S_HADD    = 25'h0000100,
        S_FMUL    = 25'h0000200,
        S_EFIN    = 25'h0000400,
        S_DINIT   = 25'h0000800,
        S_DSTEP   = 25'h0001000,
        S_DEND    = 25'h0002000,
        S_GE      = 25'h0004000,
        S_SMUL    = 25'h0008000,
        S_GV      = 25'h0010000,
        S_WMUL    = 25'h0020000,
        S_WSAT    = 25'h0040000,
        S_XMUL    = 25'h0080000,
        S_ACC     = 25'h0100000,
        S_QINIT   = 25'h0200000,
        S_QSTEP   = 25'h0400000,
        S_QEND    = 25'h0800000,
        S_EMIT    = 25'h1000000
    } state_t;

    state_t                         state_reg, state_next;
    logic                           part_reg, part_next;
    logic [2:0]                     hidx_reg, hidx_next;
    logic [tpgsa_pkg::DCNT_W-1:0]   dcnt_reg, dcnt_next;

    always_comb
    begin
        state_next = state_reg;
        part_next  = part_reg;
        hidx_next  = hidx_reg;
        dcnt_next  = dcnt_reg;
        cmd.op     = tpgsa_pkg::OP_NONE;
        cmd.part   = part_reg;
        cmd.idx    = hidx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.op = tpgsa_pkg::OP_LATCH;
                if (in_valid)
                    state_next = S_BIN_CHK;
            end
            S_BIN_CHK:
            begin
                part_next  = tpgsa_pkg::PART_BIN;
                state_next = st.use_bin ? S_ZMUL : S_GAM_CHK;
            end
            S_GAM_CHK:
            begin
                part_next  = tpgsa_pkg::PART_GAM;
                state_next = st.use_gam ? S_EXPY : S_FIN_CHK;
            end
            S_FIN_CHK:
            begin
                part_next  = tpgsa_pkg::PART_BIN;
                state_next = st.final_item ? S_QINIT : S_IDLE;
            end
            S_ZMUL:
            begin
                cmd.op     = tpgsa_pkg::OP_MUL_ZETA;
                state_next = S_EXPY;
            end
            S_EXPY:
            begin
                cmd.op     = tpgsa_pkg::OP_EXP_Y;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.op     = tpgsa_pkg::OP_EXP_SPLIT;
                hidx_next  = 3'(tpgsa_pkg::HORNER_TOP - 1);
                state_next = S_HMUL;
            end
            S_HMUL:
            begin
                cmd.op     = tpgsa_pkg::OP_HORNER_MUL;
                state_next = S_HADD;
            end
            S_HADD:
            begin
                cmd.op = tpgsa_pkg::OP_HORNER_ADD;
                if (hidx_reg == 3'd0)
                    state_next = S_FMUL;
                else
                begin
                    hidx_next  = hidx_reg - 3'd1;
                    state_next = S_HMUL;
                end
            end
            S_FMUL:
            begin
                cmd.op     = tpgsa_pkg::OP_HORNER_MUL;
                state_next = S_EFIN;
            end
            S_EFIN:
            begin
                cmd.op     = tpgsa_pkg::OP_EXP_FIN;
                state_next = (part_reg == tpgsa_pkg::PART_BIN) ? S_DINIT : S_GE;
            end
            S_DINIT:
            begin
                cmd.op     = tpgsa_pkg::OP_DIV_BIN_INIT;
                dcnt_next  = '0;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op    = tpgsa_pkg::OP_DIV_STEP;
                dcnt_next = dcnt_reg + 1'b1;
                if (&dcnt_reg)
                    state_next = S_DEND;
            end
            S_DEND:
            begin
                cmd.op     = tpgsa_pkg::OP_DIV_BIN_END;
                state_next = S_WMUL;
            end
            S_GE:
            begin
                cmd.op     = tpgsa_pkg::OP_GAM_E;
                state_next = S_SMUL;
            end
            S_SMUL:
            begin
                cmd.op     = tpgsa_pkg::OP_MUL_SE;
                state_next = S_GV;
            end
            S_GV:
            begin
                cmd.op     = tpgsa_pkg::OP_GAM_V;
                state_next = S_WMUL;
            end
            S_WMUL:
            begin
                cmd.op     = tpgsa_pkg::OP_MUL_W;
                state_next = S_WSAT;
            end
            S_WSAT:
            begin
                cmd.op     = tpgsa_pkg::OP_SAT_TMP;
                state_next = S_XMUL;
            end
            S_XMUL:
            begin
                cmd.op     = tpgsa_pkg::OP_MUL_X;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op     = tpgsa_pkg::OP_ACC;
                state_next = (part_reg == tpgsa_pkg::PART_BIN) ? S_GAM_CHK : S_FIN_CHK;
            end
            S_QINIT:
            begin
                cmd.op     = tpgsa_pkg::OP_DIV_Q_INIT;
                dcnt_next  = '0;
                state_next = S_QSTEP;
            end
            S_QSTEP:
            begin
                cmd.op    = tpgsa_pkg::OP_DIV_STEP;
                dcnt_next = dcnt_reg + 1'b1;
                if (&dcnt_reg)
                    state_next = S_QEND;
            end
            S_QEND:
            begin
                cmd.op = tpgsa_pkg::OP_DIV_Q_END;
                if (part_reg == tpgsa_pkg::PART_BIN)
                begin
                    part_next  = tpgsa_pkg::PART_GAM;
                    state_next = S_QINIT;
                end
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.op = tpgsa_pkg::OP_EMIT;
                if (st.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            part_reg  <= tpgsa_pkg::PART_BIN;
            hidx_reg  <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            part_reg  <= part_next;
            hidx_reg  <= hidx_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted word did not block input");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DSTEP && (&dcnt_reg)) |=> (state_reg == S_DEND))
        else $error("divide loop overran");

endmodule

// ===== rtl/tpgsa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpgsa_dp
// Datapath: shared multiplier, exp unit, restoring divider, accumulators.
// ----------------------------------------------------------------------------
module tpgsa_dp
#(
    parameter int FRAC_BITS = tpgsa_pkg::FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tpgsa_pkg::cmd_t     cmd,
    output tpgsa_pkg::status_t  st,
    input  logic                in_valid,
    input  logic signed [31:0]  feature_bin,
    input  logic signed [31:0]  feature_gam,
    input  logic signed [31:0]  response_bin,
    input  logic signed [31:0]  response_gam,
    input  logic signed [31:0]  weight_bin,
    input  logic signed [31:0]  weight_gam,
    input  logic signed [31:0]  linpred_bin,
    input  logic signed [31:0]  linpred_gam,
    input  logic                use_bin,
    input  logic                use_gam,
    input  logic                final_item,
    input  logic                cfg_write_en,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  grad_bin,
    output logic signed [31:0]  grad_gam,
    output logic                overflow
);

    localparam logic signed [32:0] ONE_Q     = 33'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [65:0] EXP_CLAMP = 66'(64'sd64 <<< FRAC_BITS);
    localparam logic signed [15:0] K_MAX     = 16'(60 - FRAC_BITS);
    localparam logic signed [15:0] S_OFF     = 16'(FRAC_BITS - 30);
    localparam logic [63:0]        EXP_MAX   = 64'h4000_0000_0000_0000;

    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return {1'b1, 32'h7FFF_FFFF};
        else if (v < -66'sd2147483648)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, v[31:0]};
    endfunction

    // latched word
    logic signed [31:0] x_bin_reg, x_gam_reg, z_reg, s_reg;
    logic signed [31:0] w_bin_reg, w_gam_reg, eta_bin_reg, eta_gam_reg;
    logic               use_bin_reg, use_gam_reg, final_reg;

    logic signed [65:0] prod_reg;
    logic signed [31:0] tmp_reg;
    logic signed [15:0] k_reg;
    logic               big_reg;
    logic [29:0]        f_reg;
    logic [30:0]        acc_reg;
    logic [63:0]        ex_reg;
    logic [63:0]        num_reg, den_reg, rem_reg;
    logic               neg_reg;
    logic signed [31:0] res_bin_reg, res_gam_reg;

    logic signed [63:0] sum_bin_reg, sum_gam_reg;
    logic               sat_reg;
    logic [15:0]        cnt_bin_reg, cnt_gam_reg;
    logic               out_valid_reg, overflow_reg;
    logic signed [31:0] grad_bin_reg, grad_gam_reg;

    logic               part;
    logic               out_free;
    logic signed [31:0] x_sel, w_sel;
    logic signed [65:0] prod_shf, y_raw, t_full;
    logic signed [32:0] y_cl;
    logic signed [32:0] mul_a, mul_b;
    logic               mul_en;
    logic signed [15:0] s_val, ns_val;
    logic [31:0]        m_val;
    logic [63:0]        ex_next;
    logic [64:0]        rem_sh;
    logic               q_bit;
    logic [63:0]        div_num_init;
    logic signed [63:0] sum_sel;
    logic [32:0]        abs_z;
    logic signed [64:0] q_signed;
    logic signed [63:0] g_signed;
    logic [32:0]        sat_a, sat_b;
    logic signed [64:0] add_r;
    logic signed [63:0] add_val;
    logic               add_ovf;

    assign part     = cmd.part;
    assign out_free = !out_valid_reg || !out_stall;
    assign x_sel    = (part == tpgsa_pkg::PART_GAM) ? x_gam_reg : x_bin_reg;
    assign w_sel    = (part == tpgsa_pkg::PART_GAM) ? w_gam_reg : w_bin_reg;
    assign sum_sel  = (part == tpgsa_pkg::PART_GAM) ? sum_gam_reg : sum_bin_reg;
    assign prod_shf = prod_reg >>> FRAC_BITS;
    assign t_full   = prod_reg >>> 30;

    always_comb
    begin
        if (part == tpgsa_pkg::PART_GAM)
            y_raw = -{{34{eta_gam_reg[31]}}, eta_gam_reg};
        else
            y_raw = prod_shf;
        if (y_raw > EXP_CLAMP)
            y_cl = EXP_CLAMP[32:0];
        else if (y_raw < -EXP_CLAMP)
            y_cl = 33'(-EXP_CLAMP);
        else
            y_cl = y_raw[32:0];
    end

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd.op)
            tpgsa_pkg::OP_MUL_ZETA:
            begin
                mul_a = {z_reg[31], z_reg};
                mul_b = {eta_bin_reg[31], eta_bin_reg};
            end
            tpgsa_pkg::OP_EXP_Y:
            begin
                mul_a = y_cl;
                mul_b = tpgsa_pkg::LOG2E_Q30;
            end
            tpgsa_pkg::OP_HORNER_MUL:
            begin
                mul_a = {2'b00, acc_reg};
                mul_b = {3'b000, f_reg};
            end
            tpgsa_pkg::OP_MUL_SE:
            begin
                mul_a = {s_reg[31], s_reg};
                mul_b = {tmp_reg[31], tmp_reg};
            end
            tpgsa_pkg::OP_MUL_W:
            begin
                mul_a = {w_sel[31], w_sel};
                mul_b = {tmp_reg[31], tmp_reg};
            end
            tpgsa_pkg::OP_MUL_X:
            begin
                mul_a = {x_sel[31], x_sel};
                mul_b = {tmp_reg[31], tmp_reg};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // 2^k scaling of the polynomial result
    always_comb
    begin
        s_val  = k_reg + S_OFF;
        ns_val = -s_val;
        m_val  = 32'h4000_0000 + prod_reg[61:30];
        if (big_reg)
            ex_next = EXP_MAX;
        else if (!s_val[15])
            ex_next = {32'b0, m_val} << s_val[4:0];
        else if (ns_val >= 16'sd63)
            ex_next = '0;
        else
            ex_next = {32'b0, m_val} >> ns_val[5:0];
    end

    // restoring divide step
    always_comb
    begin
        rem_sh = {rem_reg, num_reg[63]};
        q_bit  = (rem_sh >= {1'b0, den_reg});
    end

    assign abs_z        = z_reg[31] ? 33'(-{z_reg[31], z_reg}) : {1'b0, z_reg};
    assign div_num_init = sum_sel[63] ? 64'(-sum_sel) : 64'(sum_sel);
    assign g_signed     = neg_reg ? -$signed(num_reg) : $signed(num_reg);
    assign q_signed     = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});

    always_comb
    begin
        sat_a = '0;
        sat_b = '0;
        case (cmd.op)
            tpgsa_pkg::OP_GAM_E:
                sat_a = sat32($signed({2'b00, ex_reg}));
            tpgsa_pkg::OP_GAM_V:
            begin
                sat_a = sat32(prod_shf);
                sat_b = sat32(66'($signed(sat_a[31:0])) - 66'(ONE_Q));
            end
            tpgsa_pkg::OP_SAT_TMP, tpgsa_pkg::OP_ACC:
                sat_a = sat32(prod_shf);
            tpgsa_pkg::OP_DIV_Q_END:
                sat_a = sat32(66'(q_signed));
            default:
            begin
                sat_a = '0;
                sat_b = '0;
            end
        endcase
    end

    always_comb
    begin
        add_r   = {sum_sel[63], sum_sel} + 65'($signed(sat_a[31:0]));
        add_ovf = (add_r[64] != add_r[63]);
        if (add_ovf)
            add_val = add_r[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        else
            add_val = add_r[63:0];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == tpgsa_pkg::OP_LATCH && in_valid)
        begin
            x_bin_reg   <= feature_bin;
            x_gam_reg   <= feature_gam;
            z_reg       <= response_bin;
            s_reg       <= response_gam;
            w_bin_reg   <= weight_bin;
            w_gam_reg   <= weight_gam;
            eta_bin_reg <= linpred_bin;
            eta_gam_reg <= linpred_gam;
            use_bin_reg <= use_bin;
            use_gam_reg <= use_gam;
            final_reg   <= final_item;
        end
        if (mul_en)
            prod_reg <= mul_a * mul_b;
        case (cmd.op)
            tpgsa_pkg::OP_EXP_SPLIT:
            begin
                k_reg   <= 16'(t_full >>> FRAC_BITS);
                big_reg <= $signed(16'(t_full >>> FRAC_BITS)) > K_MAX;
                f_reg   <= t_full[29:0] << (30 - FRAC_BITS);
                acc_reg <= 31'(tpgsa_pkg::POW2_COEF[tpgsa_pkg::HORNER_TOP]);
            end
            tpgsa_pkg::OP_HORNER_ADD:
                acc_reg <= 31'(tpgsa_pkg::POW2_COEF[cmd.idx]) + prod_reg[60:30];
            tpgsa_pkg::OP_EXP_FIN:
                ex_reg <= ex_next;
            tpgsa_pkg::OP_DIV_BIN_INIT:
            begin
                num_reg <= 64'(abs_z) << FRAC_BITS;
                den_reg <= 64'(ONE_Q) + ex_reg;
                rem_reg <= '0;
                neg_reg <= z_reg[31];
            end
            tpgsa_pkg::OP_DIV_Q_INIT:
            begin
                num_reg <= div_num_init;
                if (part == tpgsa_pkg::PART_GAM)
                    den_reg <= (cnt_gam_reg == '0) ? 64'd1 : 64'(cnt_gam_reg);
                else
                    den_reg <= (cnt_bin_reg == '0) ? 64'd1 : 64'(cnt_bin_reg);
                rem_reg <= '0;
                neg_reg <= sum_sel[63];
            end
            tpgsa_pkg::OP_DIV_STEP:
            begin
                rem_reg <= q_bit ? 64'(rem_sh - {1'b0, den_reg}) : rem_sh[63:0];
                num_reg <= {num_reg[62:0], q_bit};
            end
            tpgsa_pkg::OP_DIV_BIN_END:
                tmp_reg <= g_signed[31:0];
            tpgsa_pkg::OP_GAM_E, tpgsa_pkg::OP_SAT_TMP:
                tmp_reg <= sat_a[31:0];
            tpgsa_pkg::OP_GAM_V:
                tmp_reg <= sat_b[31:0];
            tpgsa_pkg::OP_DIV_Q_END:
            begin
                if (part == tpgsa_pkg::PART_GAM)
                    res_gam_reg <= sat_a[31:0];
                else
                    res_bin_reg <= sat_a[31:0];
            end
            default:
            begin
            end
        endcase
        if (cmd.op == tpgsa_pkg::OP_EMIT && out_free)
        begin
            grad_bin_reg <= res_bin_reg;
            grad_gam_reg <= res_gam_reg;
            overflow_reg <= sat_reg;
        end
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_bin_reg   <= '0;
            sum_gam_reg   <= '0;
            sat_reg       <= 1'b0;
            cnt_bin_reg   <= 16'd1;
            cnt_gam_reg   <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index)
                    cnt_gam_reg <= cfg_data;
                else
                    cnt_bin_reg <= cfg_data;
            end
            case (cmd.op)
                tpgsa_pkg::OP_GAM_E, tpgsa_pkg::OP_SAT_TMP, tpgsa_pkg::OP_DIV_Q_END:
                    sat_reg <= sat_reg | sat_a[32];
                tpgsa_pkg::OP_GAM_V:
                    sat_reg <= sat_reg | sat_a[32] | sat_b[32];
                tpgsa_pkg::OP_ACC:
                begin
                    sat_reg <= sat_reg | sat_a[32] | add_ovf;
                    if (part == tpgsa_pkg::PART_GAM)
                        sum_gam_reg <= add_val;
                    else
                        sum_bin_reg <= add_val;
                end
                tpgsa_pkg::OP_EMIT:
                begin
                    if (out_free)
                    begin
                        sum_bin_reg <= '0;
                        sum_gam_reg <= '0;
                        sat_reg     <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            if (cmd.op == tpgsa_pkg::OP_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign st.use_bin    = use_bin_reg;
    assign st.use_gam    = use_gam_reg;
    assign st.final_item = final_reg;
    assign st.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign grad_bin  = grad_bin_reg;
    assign grad_gam  = grad_gam_reg;
    assign overflow  = overflow_reg;

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == tpgsa_pkg::OP_EMIT && out_free)
        |=> (sum_bin_reg == '0 && sum_gam_reg == '0 && !sat_reg && out_valid_reg))
        else $error("emit did not clear accumulators");

    a_exp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == tpgsa_pkg::OP_EXP_FIN) |=> (ex_reg <= EXP_MAX))
        else $error("exp result above limit");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == tpgsa_pkg::OP_DIV_STEP) |-> (den_reg != '0))
        else $error("divide by zero");

endmodule

// ===== rtl/two_part_glm_score_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_part_glm_score_accumulator
// Accumulates logistic and gamma gradient sums; emits sum/count on last word.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in      | input     | in_valid / in_stall   | features, responses, weights,
//           |           |                       | linpreds, use bits, final_item
//   out     | output    | out_valid / out_stall | grad_bin, grad_gam, overflow
//   cfg     | input     | cfg_write_en          | cfg_index, cfg_data
//
// One word at a time. The binomial part runs the exp (7 Horner multiplies)
// and a 64-step divide; the gamma part also runs the exp; a final word
// runs two 64-step divides plus the emit.
// The multiplier is a shared 33x33 unit and the divider is bit-serial.
// Reset clears sums, overflow flag, output valid; counts reset to 1.
// Results wait in an output register; a stalled result holds the next final.
// ----------------------------------------------------------------------------
module two_part_glm_score_accumulator
#(
    parameter int FRAC_BITS = tpgsa_pkg::FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] feature_bin,
    input  logic signed [31:0] feature_gam,
    input  logic signed [31:0] response_bin,
    input  logic signed [31:0] response_gam,
    input  logic signed [31:0] weight_bin,
    input  logic signed [31:0] weight_gam,
    input  logic signed [31:0] linpred_bin,
    input  logic signed [31:0] linpred_gam,
    input  logic               use_bin,
    input  logic               use_gam,
    input  logic               final_item,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] grad_bin,
    output logic signed [31:0] grad_gam,
    output logic               overflow,
    input  logic               cfg_write_en,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    tpgsa_pkg::cmd_t    cmd;
    tpgsa_pkg::status_t st;

    tpgsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    tpgsa_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .in_valid     (in_valid),
        .feature_bin  (feature_bin),
        .feature_gam  (feature_gam),
        .response_bin (response_bin),
        .response_gam (response_gam),
        .weight_bin   (weight_bin),
        .weight_gam   (weight_gam),
        .linpred_bin  (linpred_bin),
        .linpred_gam  (linpred_gam),
        .use_bin      (use_bin),
        .use_gam      (use_gam),
        .final_item   (final_item),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .grad_bin     (grad_bin),
        .grad_gam     (grad_gam),
        .overflow     (overflow)
    );

endmodule

// ===== test/two_part_glm_score_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_part_glm_score_checker
// Watches the input, output and register ports of the score accumulator.
// Every accepted word goes through a fixed-point model of both gradient
// terms. The model queues a gradient pair on each final word, and the queue
// is compared field by field with each accepted result.
// ----------------------------------------------------------------------------
module two_part_glm_score_checker
#(
    parameter int FRAC = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] feature_bin,
    input  logic signed [31:0] feature_gam,
    input  logic signed [31:0] response_bin,
    input  logic signed [31:0] response_gam,
    input  logic signed [31:0] weight_bin,
    input  logic signed [31:0] weight_gam,
    input  logic signed [31:0] linpred_bin,
    input  logic signed [31:0] linpred_gam,
    input  logic               use_bin,
    input  logic               use_gam,
    input  logic               final_item,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] grad_bin,
    input  logic signed [31:0] grad_gam,
    input  logic               overflow,
    input  logic               cfg_write_en,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 outstanding
);

    localparam logic IDX_COUNT_BIN = 1'b0;
    localparam logic IDX_COUNT_GAM = 1'b1;
    localparam longint ONE_Q = longint'(1) <<< FRAC;
    localparam longint LOG2E = 64'sd1549082005;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S64_MAX = 64'h7fffffffffffffff;
    localparam longint S64_MIN = 64'h8000000000000000;
    localparam logic [63:0] TAYLOR [0:6] = '{
        64'd744261118, 64'd257941248, 64'd59597083, 64'd10327388,
        64'd1431680, 64'd165394, 64'd16378
    };

    typedef struct {
        logic signed [31:0] gb;
        logic signed [31:0] gg;
        logic               ovf;
    } grad_pair_t;

    grad_pair_t   grad_fifo[$];
    longint       acc_bin;
    longint       acc_gam;
    bit           sat_flag;
    logic [15:0]  cnt_bin;
    logic [15:0]  cnt_gam;

    assign outstanding = grad_fifo.size();

    function automatic longint clip32(longint v, inout bit flag);
        if (v > S32_MAX)
        begin
            flag = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN)
        begin
            flag = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    function automatic longint fxmul(longint a, longint b);
        return (a * b) >>> FRAC;
    endfunction

    function automatic longint add_clip64(longint a, longint b, inout bit flag);
        if (b > 0 && a > S64_MAX - b)
        begin
            flag = 1'b1;
            return S64_MAX;
        end
        if (b < 0 && a < S64_MIN - b)
        begin
            flag = 1'b1;
            return S64_MIN;
        end
        return a + b;
    endfunction

    function automatic longint fixed_exp(longint y);
        longint      t;
        longint      k;
        longint      s;
        logic [63:0] f;
        logic [63:0] acc;
        logic [63:0] m;
        if (y > (longint'(64) <<< FRAC))
            y = longint'(64) <<< FRAC;
        if (y < -(longint'(64) <<< FRAC))
            y = -(longint'(64) <<< FRAC);
        t = (y * LOG2E) >>> 30;
        k = t >>> FRAC;
        if (k > 60 - FRAC)
            return longint'(1) <<< 62;
        f = (64'(t) & ((64'd1 << FRAC) - 64'd1)) << (30 - FRAC);
        acc = TAYLOR[6];
        for (int i = 5; i >= 0; i--)
            acc = TAYLOR[i] + ((acc * f) >> 30);
        m = (64'd1 << 30) + ((acc * f) >> 30);
        s = k + FRAC - 30;
        if (s >= 0)
            return longint'(m << s);
        if (-s >= 63)
            return 0;
        return longint'(m >> (-s));
    endfunction

    function automatic longint logistic_term(longint x, longint w, longint z, longint eta,
                                             inout bit flag);
        longint d;
        longint g;
        longint h;
        d = ONE_Q + fixed_exp(fxmul(z, eta));
        g = (z * ONE_Q) / d;
        h = clip32(fxmul(w, g), flag);
        return clip32(fxmul(x, h), flag);
    endfunction

    function automatic longint gamma_term(longint x, longint w, longint s, longint eta,
                                          inout bit flag);
        longint e;
        longint u;
        longint v;
        longint h;
        e = clip32(fixed_exp(-eta), flag);
        u = clip32(fxmul(s, e), flag);
        v = clip32(u - ONE_Q, flag);
        h = clip32(fxmul(w, v), flag);
        return clip32(fxmul(x, h), flag);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        longint     cb;
        longint     cg;
        grad_pair_t p;
        grad_pair_t got;
        if (!rst_n)
        begin
            acc_bin = 0;
            acc_gam = 0;
            sat_flag = 1'b0;
            cnt_bin = 16'd1;
            cnt_gam = 16'd1;
            fail_count = 0;
            grad_fifo.delete();
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == IDX_COUNT_BIN)
                    cnt_bin = cfg_data;
                else if (cfg_index == IDX_COUNT_GAM)
                    cnt_gam = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                got.gb = grad_bin;
                got.gg = grad_gam;
                got.ovf = overflow;
                if (grad_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result word grad_bin=%0d grad_gam=%0d",
                             $time, got.gb, got.gg);
                    fail_count++;
                end
                else
                begin
                    p = grad_fifo.pop_front();
                    if (got.gb !== p.gb)
                    begin
                        $display("%0t: grad_bin expected %0d actual %0d", $time, p.gb, got.gb);
                        fail_count++;
                    end
                    if (got.gg !== p.gg)
                    begin
                        $display("%0t: grad_gam expected %0d actual %0d", $time, p.gg, got.gg);
                        fail_count++;
                    end
                    if (got.ovf !== p.ovf)
                    begin
                        $display("%0t: overflow expected %0b actual %0b", $time, p.ovf, got.ovf);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (use_bin)
                    acc_bin = add_clip64(acc_bin,
                        logistic_term(feature_bin, weight_bin, response_bin, linpred_bin,
                                      sat_flag), sat_flag);
                if (use_gam)
                    acc_gam = add_clip64(acc_gam,
                        gamma_term(feature_gam, weight_gam, response_gam, linpred_gam,
                                   sat_flag), sat_flag);
                if (final_item)
                begin
                    cb = (cnt_bin == 0) ? 1 : longint'(cnt_bin);
                    cg = (cnt_gam == 0) ? 1 : longint'(cnt_gam);
                    p.gb = 32'(clip32(acc_bin / cb, sat_flag));
                    p.gg = 32'(clip32(acc_gam / cg, sat_flag));
                    p.ovf = sat_flag;
                    grad_fifo.push_back(p);
                    acc_bin = 0;
                    acc_gam = 0;
                    sat_flag = 1'b0;
                end
            end
        end
    end

endmodule

// ===== test/two_part_glm_score_accumulator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_part_glm_score_accumulator_test
// Drives observation words, register writes and output back-pressure into
// the score accumulator. The checker beside it predicts and compares. The
// run covers directed corner words, then random batches under several count
// settings, with random gaps and stalls, and a final burst with neither.
// ----------------------------------------------------------------------------
module two_part_glm_score_accumulator_test;

    localparam logic IDX_COUNT_BIN = 1'b0;
    localparam logic IDX_COUNT_GAM = 1'b1;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   DRAIN_CYCLES = 400;
    localparam int   PMAX = 32'h7fffffff;
    localparam int   NMIN = 32'h80000000;
    localparam int   Q1 = 65536;

    typedef struct {
        int fb, fg, rb, rg, wb, wg, lb, lg;
        bit ub, ug, fin;
    } obs_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] feature_bin = '0;
    logic signed [31:0] feature_gam = '0;
    logic signed [31:0] response_bin = '0;
    logic signed [31:0] response_gam = '0;
    logic signed [31:0] weight_bin = '0;
    logic signed [31:0] weight_gam = '0;
    logic signed [31:0] linpred_bin = '0;
    logic signed [31:0] linpred_gam = '0;
    logic               use_bin = 1'b0;
    logic               use_gam = 1'b0;
    logic               final_item = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] grad_bin;
    logic signed [31:0] grad_gam;
    logic               overflow;
    logic               cfg_write_en = 1'b0;
    logic               cfg_index = 1'b0;
    logic [15:0]        cfg_data = '0;
    int                 fail_count;
    int                 outstanding;
    bit                 quiet = 1'b0;
    int                 stall_left = 0;
    int                 idle_cycles = 0;

    always #4 clk = ~clk;

    two_part_glm_score_accumulator DUT (.*);

    two_part_glm_score_checker CHK (.*);

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic obs_word_t mk(int fb, int fg, int rb, int rg, int wb, int wg,
                                     int lb, int lg, bit ub, bit ug, bit fin);
        obs_word_t w;
        w = '{fb, fg, rb, rg, wb, wg, lb, lg, ub, ug, fin};
        return w;
    endfunction

    function automatic int near(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic obs_word_t random_word(int final_odds);
        obs_word_t w;
        if ($urandom_range(0, 9) < 7)
        begin
            w.fb = near(4 * Q1);
            w.fg = near(4 * Q1);
            w.rb = $urandom_range(0, 1) ? Q1 : -Q1;
            w.rg = $urandom_range(0, 8 * Q1);
            w.wb = $urandom_range(0, 2 * Q1);
            w.wg = $urandom_range(0, 2 * Q1);
            w.lb = near(8 * Q1);
            w.lg = near(8 * Q1);
        end
        else
        begin
            w.fb = $urandom;
            w.fg = $urandom;
            w.rb = $urandom;
            w.rg = $urandom;
            w.wb = $urandom;
            w.wg = $urandom;
            w.lb = $urandom_range(0, 1) ? int'($urandom) : near(80 * Q1);
            w.lg = $urandom_range(0, 1) ? int'($urandom) : near(80 * Q1);
        end
        w.ub = $urandom_range(0, 3) != 0;
        w.ug = $urandom_range(0, 3) != 0;
        w.fin = $urandom_range(0, final_odds) == 0;
        return w;
    endfunction

    task automatic send(obs_word_t w);
        in_valid <= 1'b1;
        feature_bin <= w.fb;
        feature_gam <= w.fg;
        response_bin <= w.rb;
        response_gam <= w.rg;
        weight_bin <= w.wb;
        weight_gam <= w.wg;
        linpred_bin <= w.lb;
        linpred_gam <= w.lg;
        use_bin <= w.ub;
        use_gam <= w.ug;
        final_item <= w.fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_counts(logic [15:0] cb, logic [15:0] cg);
        cfg_write_en <= 1'b1;
        cfg_index <= IDX_COUNT_BIN;
        cfg_data <= cb;
        @(posedge clk);
        cfg_index <= IDX_COUNT_GAM;
        cfg_data <= cg;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic random_batch(int n);
        repeat (n) send(random_word(11));
        send(random_word(0));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1));
        send(mk(Q1, Q1, Q1, Q1, Q1, Q1, Q1, Q1, 0, 0, 1));
        send(mk(2 * Q1, 0, Q1, 0, Q1, 0, Q1 / 2, 0, 1, 0, 0));
        send(mk(0, -3 * Q1, 0, 2 * Q1, 0, Q1, 0, -Q1, 0, 1, 0));
        send(mk(Q1, Q1, -Q1, Q1, Q1, Q1, Q1, Q1, 1, 1, 1));
        send(mk(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 1, 1, 1));
        send(mk(NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, 1, 1, 1));
        send(mk(PMAX, NMIN, NMIN, PMAX, NMIN, PMAX, PMAX, NMIN, 1, 1, 1));
        send(mk(-1, -1, -1, -1, -1, -1, -1, -1, 1, 1, 1));
        send(mk(Q1, Q1, Q1, Q1, Q1, Q1, 100 * Q1, 100 * Q1, 1, 1, 0));
        send(mk(Q1, Q1, -Q1, Q1, Q1, Q1, 100 * Q1, -100 * Q1, 1, 1, 1));
        send(mk(Q1, Q1, Q1, Q1, Q1, Q1, 64 * Q1, -64 * Q1, 1, 1, 1));
        send(mk(Q1, Q1, Q1, Q1, Q1, Q1, 44 * Q1, -30 * Q1, 1, 1, 1));
        send(mk(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, -PMAX, -PMAX, 1, 1, 0));
        send(mk(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, -PMAX, -PMAX, 1, 1, 0));
        send(mk(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, -PMAX, -PMAX, 1, 1, 1));
        send(mk(1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
        send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));

        settle();
        write_counts(16'd0, 16'd0);
        send(mk(3 * Q1, 3 * Q1, Q1, 5 * Q1, Q1, Q1, Q1, Q1, 1, 1, 1));
        random_batch(300);

        settle();
        write_counts(16'd65535, 16'd1);
        random_batch(300);

        settle();
        write_counts(16'd1, 16'd65535);
        random_batch(300);

        settle();
        write_counts(16'd7, 16'd3);
        random_batch(300);

        settle();
        write_counts(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        random_batch(300);

        settle();
        write_counts(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)));
        quiet = 1'b1;
        random_batch(300);

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
